@@ design/tmcr_pkg.sv @@
// Package for the text-mode cell renderer: sizes, action codes and the
// command word that runs from the front end through the queue to the back end.
// No dependencies.
package tmcr_pkg;

   // Screen and glyph geometry
   localparam int TEXT_ROWS   = 24;
   localparam int TEXT_COLS   = 40;
   localparam int GLYPH_LINES = 8;
   localparam int CELL_WIDTH  = 7;

   // Stores
   localparam int PAGE_DEPTH   = 1024;
   localparam int FONT_DEPTH   = 2048;
   localparam int PAGE_AW      = $clog2(PAGE_DEPTH);
   localparam int FONT_AW      = $clog2(FONT_DEPTH);
   localparam int GROUP_STRIDE = 128;
   localparam int BAND_STRIDE  = 40;

   // Glyph and line indexing
   localparam int LINE_W  = $clog2(GLYPH_LINES);
   localparam int GLYPH_W = 7;

   // Frame counter bit that sets the flash phase
   localparam int FLASH_BIT = 4;

   // Command queue, depth must be a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      ACT_TEXT_WR = 2'd0,
      ACT_FONT_WR = 2'd1,
      ACT_RENDER  = 2'd2,
      ACT_TICK    = 2'd3
   } action_type;

   // Classified command: address is the store address for writes or the
   // interleaved cell address for a render
   typedef struct packed {
      action_type         kind;
      logic [FONT_AW-1:0] mem_addr;
      logic [7:0]         data;
      logic [7:0]         line_base;
      logic [8:0]         pixel_x;
   } cmd_type;

endpackage

@@ design/tmcr_front.sv @@
// Front end of the text-mode cell renderer: registers each accepted word,
// drops text writes past the page and renders off the screen, and works out
// the cell address and screen position. Depends on tmcr_pkg.
module tmcr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [1:0]          req_action,
   input  logic [10:0]         req_store_address,
   input  logic [7:0]          req_store_byte,
   input  logic [4:0]          req_cell_row,
   input  logic [5:0]          req_cell_col,
   output logic                cmd_valid,
   output tmcr_pkg::cmd_type   cmd
);
   import tmcr_pkg::*;

   logic                 keep;
   logic [PAGE_AW-1:0]   cell_addr;
   logic [1:0]           band;
   cmd_type              cmd_in;
   cmd_type              cmd_ff;
   logic                 valid_in;
   logic                 valid_ff;

   // Interleaved address: (row mod 8)*128 + (row div 8)*40 + col
   always_comb begin
      band      = req_cell_row[4:3];
      cell_addr = PAGE_AW'({req_cell_row[2:0], 7'b0000000})
                + PAGE_AW'(band * BAND_STRIDE)
                + PAGE_AW'(req_cell_col);
   end

   // Classify the request
   always_comb begin
      cmd_in.kind      = action_type'(req_action);
      cmd_in.mem_addr  = req_store_address;
      cmd_in.data      = req_store_byte;
      cmd_in.line_base = {req_cell_row, 3'b000};
      cmd_in.pixel_x   = {req_cell_col, 3'b000} - {3'b000, req_cell_col};
      keep             = 1'b1;
      unique case (action_type'(req_action))
         ACT_TEXT_WR: begin
            keep = req_store_address < 11'(PAGE_DEPTH);
         end
         ACT_FONT_WR: begin
            keep = 1'b1;
         end
         ACT_RENDER: begin
            keep = (req_cell_row < 5'(TEXT_ROWS)) && (req_cell_col < 6'(TEXT_COLS));
            cmd_in.mem_addr = FONT_AW'(cell_addr);
         end
         ACT_TICK: begin
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
      valid_in = accept && keep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_in) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule

@@ design/tmcr_queue.sv @@
// Short command queue between front and back end of the text-mode cell renderer.
// Depends on tmcr_pkg.
module tmcr_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tmcr_pkg::cmd_type         push_cmd,
   input  logic                      pop,
   output logic                      not_empty,
   output tmcr_pkg::cmd_type         head,
   output logic [tmcr_pkg::QCNT_W-1:0] count
);
   import tmcr_pkg::*;

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                do_pop;

   // Pointers wrap naturally at the power-of-two depth
   always_comb begin
      do_pop    = pop && (count_ff != '0);
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

@@ design/tmcr_back.sv @@
// Back end of the text-mode cell renderer: holds the text page, the character
// store and the frame counter, and plays out each command. Depends on tmcr_pkg.
module tmcr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  tmcr_pkg::cmd_type cmd,
   output logic              pop,
   output logic              rsp_strobe,
   output logic [7:0]        rsp_line_y,
   output logic [8:0]        rsp_pixel_x,
   output logic [6:0]        rsp_lit_mask,
   output logic              rsp_last_line
);
   import tmcr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CODE = 3'b010,
      S_EMIT = 3'b100
   } state_type;

   logic [7:0]          text_page [PAGE_DEPTH];
   logic [7:0]          font_store [FONT_DEPTH];

   state_type           state_ff;
   state_type           state_in;
   logic [7:0]          frame_ff;
   logic [7:0]          frame_in;
   logic [LINE_W-1:0]   line_ff;
   logic [LINE_W-1:0]   line_in;
   logic [7:0]          line_base_ff;
   logic [8:0]          pixel_x_ff;
   logic                invert_ff;
   logic                invert_in;
   logic [GLYPH_W-1:0]  glyph_ff;
   logic [GLYPH_W-1:0]  glyph_in;
   logic [7:0]          text_q_ff;
   logic [7:0]          font_q_ff;

   logic                take;
   logic                text_we;
   logic                font_we;
   logic                text_re;
   logic                font_re;
   logic [FONT_AW-1:0]  font_raddr;
   logic                last;

   assign take = (state_ff == S_IDLE) && cmd_valid;
   assign last = (line_ff == LINE_W'(GLYPH_LINES - 1));

   // Code decode: inverse, flash or normal by range
   always_comb begin
      if (text_q_ff[7]) begin
         glyph_in  = text_q_ff[6:0];
         invert_in = 1'b0;
      end else if (text_q_ff[6]) begin
         glyph_in  = {1'b0, text_q_ff[5:0]};
         invert_in = ~frame_ff[FLASH_BIT];
      end else begin
         glyph_in  = {1'b1, text_q_ff[5:0]};
         invert_in = 1'b1;
      end
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      frame_in   = frame_ff;
      line_in    = line_ff;
      text_we    = 1'b0;
      font_we    = 1'b0;
      text_re    = 1'b0;
      font_re    = 1'b0;
      font_raddr = {1'b0, glyph_ff, line_ff + 1'b1};
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.kind)
                  ACT_TEXT_WR: text_we  = 1'b1;
                  ACT_FONT_WR: font_we  = 1'b1;
                  ACT_TICK:    frame_in = frame_ff - 8'd1;
                  ACT_RENDER: begin
                     text_re  = 1'b1;
                     state_in = S_CODE;
                  end
                  default: ;
               endcase
            end
         end
         S_CODE: begin
            // first glyph line fetch
            font_re    = 1'b1;
            font_raddr = {1'b0, glyph_in, LINE_W'(0)};
            line_in    = '0;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            if (last) begin
               state_in = S_IDLE;
            end else begin
               font_re = 1'b1;
               line_in = line_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         frame_ff <= 8'd0;
      end else begin
         state_ff <= state_in;
         frame_ff <= frame_in;
      end
   end

   // Render context
   always_ff @(posedge clock) begin
      line_ff <= line_in;
      if (take) begin
         line_base_ff <= cmd.line_base;
         pixel_x_ff   <= cmd.pixel_x;
      end
      if (state_ff == S_CODE) begin
         glyph_ff  <= glyph_in;
         invert_ff <= invert_in;
      end
   end

   // Text page
   always_ff @(posedge clock) begin
      if (text_we) begin
         text_page[cmd.mem_addr[PAGE_AW-1:0]] <= cmd.data;
      end
      if (text_re) begin
         text_q_ff <= text_page[cmd.mem_addr[PAGE_AW-1:0]];
      end
   end

   // Character store
   always_ff @(posedge clock) begin
      if (font_we) begin
         font_store[cmd.mem_addr] <= cmd.data;
      end
      if (font_re) begin
         font_q_ff <= font_store[font_raddr];
      end
   end

   assign pop           = take;
   assign rsp_strobe    = (state_ff == S_EMIT);
   assign rsp_line_y    = line_base_ff + 8'(line_ff);
   assign rsp_pixel_x   = pixel_x_ff;
   assign rsp_lit_mask  = invert_ff ? ~font_q_ff[6:0] : font_q_ff[6:0];
   assign rsp_last_line = last;

endmodule

@@ design/text_mode_cell_renderer_top.sv @@
// Top level of the text-mode cell renderer: front end, command queue, back end.
// Depends on tmcr_pkg, tmcr_front, tmcr_queue and tmcr_back.
//
//   channel   ports                                     handshake
//   request   req_action, req_store_address,            start high, busy low
//             req_store_byte, req_cell_row, req_cell_col
//   result    rsp_line_y, rsp_pixel_x, rsp_lit_mask,    rsp_strobe, one cycle
//             rsp_last_line
//
// A write or a frame tick is done as the back end pops it. A render steps
// through one text page read, one font read to start the glyph, then eight
// results with the next font line read under each but the last; no new word
// is popped until it ends. Words are taken while the four-entry queue has room.
// Reset is synchronous; the stores are not cleared. Results cannot be held off.
module text_mode_cell_renderer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [10:0] req_store_address,
   input  logic [7:0]  req_store_byte,
   input  logic [4:0]  req_cell_row,
   input  logic [5:0]  req_cell_col,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_line_y,
   output logic [8:0]  rsp_pixel_x,
   output logic [6:0]  rsp_lit_mask,
   output logic        rsp_last_line
);
   import tmcr_pkg::*;

   logic               accept;
   logic               front_valid;
   cmd_type            front_cmd;
   logic               q_not_empty;
   cmd_type            q_head;
   logic [QCNT_W-1:0]  q_count;
   logic               back_pop;
   logic [QCNT_W:0]    pending;

   // Room check counts the word sitting in the front register
   assign pending = {1'b0, q_count} + {{QCNT_W{1'b0}}, front_valid};
   assign busy    = reset || (pending >= (QCNT_W + 1)'(QUEUE_DEPTH));
   assign accept  = start && !busy;

   tmcr_front u_front (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .req_action        (req_action),
      .req_store_address (req_store_address),
      .req_store_byte    (req_store_byte),
      .req_cell_row      (req_cell_row),
      .req_cell_col      (req_cell_col),
      .cmd_valid         (front_valid),
      .cmd               (front_cmd)
   );

   tmcr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_cmd  (front_cmd),
      .pop       (back_pop),
      .not_empty (q_not_empty),
      .head      (q_head),
      .count     (q_count)
   );

   tmcr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (q_not_empty),
      .cmd           (q_head),
      .pop           (back_pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_line_y    (rsp_line_y),
      .rsp_pixel_x   (rsp_pixel_x),
      .rsp_lit_mask  (rsp_lit_mask),
      .rsp_last_line (rsp_last_line)
   );

endmodule

@@ design/tmcr_checker.sv @@
// Port-level checks for the text-mode cell renderer, bound to the top level.
// Depends on text_mode_cell_renderer_top.
module tmcr_checker (
   input logic       clock,
   input logic       reset,
   input logic       busy,
   input logic       rsp_strobe,
   input logic [7:0] rsp_line_y,
   input logic [8:0] rsp_pixel_x,
   input logic       rsp_last_line
);

   // Nothing is taken during reset and nothing comes out straight after it
   a_reset_quiet: assert property (@(posedge clock)
      reset |-> (busy ##1 !rsp_strobe))
      else $error("result or accept straight after reset");

   // Lines of one cell come back to back
   a_lines_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_line) |=> rsp_strobe)
      else $error("gap inside a cell");

   // Each following line steps down by one, same x
   a_line_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_line) |=>
         ((rsp_line_y == $past(rsp_line_y) + 8'd1) && $stable(rsp_pixel_x)))
      else $error("line position out of step");

   // Last line flag matches the glyph line position
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_last_line == (rsp_line_y[2:0] == 3'd7)))
      else $error("last line flag misplaced");

   // A new cell cannot follow the last line at once
   a_cell_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_line) |=> !rsp_strobe)
      else $error("cell follows without a gap");

endmodule

bind text_mode_cell_renderer_top tmcr_checker u_tmcr_checker (
   .clock         (clock),
   .reset         (reset),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_line_y    (rsp_line_y),
   .rsp_pixel_x   (rsp_pixel_x),
   .rsp_last_line (rsp_last_line)
);
